// ===== sv/pfc_pkg.sv =====
// Shared types, constants and the microcode program of the particle sensor frame checker.
// Used by pfc_sequencer, pfc_datapath and particle_sensor_frame_checker; no dependencies.
`timescale 1ns / 1ps

package pfc_pkg;

    localparam int STORE_DEPTH = 31;
    localparam int ADDR_W      = 5;
    localparam int COUNT_W     = 6;
    localparam int SUM_W       = 13;
    localparam int STEP_W      = 3;

    localparam logic [7:0]         HDR_FIRST    = 8'h42;
    localparam logic [7:0]         HDR_SECOND   = 8'h4D;
    localparam logic [7:0]         LEN_HIGH     = 8'd0;
    localparam logic [7:0]         LEN_LOW      = 8'd28;
    localparam logic [COUNT_W-1:0] POS_HDR0     = 6'd0;
    localparam logic [COUNT_W-1:0] POS_HDR1     = 6'd1;
    localparam logic [COUNT_W-1:0] POS_LEN0     = 6'd2;
    localparam logic [COUNT_W-1:0] POS_LEN1     = 6'd3;
    localparam logic [COUNT_W-1:0] POS_ERRCODE  = 6'd29;
    localparam logic [COUNT_W-1:0] POS_CHECK_HI = 6'd30;
    localparam logic [COUNT_W-1:0] POS_LAST     = 6'd31;

    localparam logic [3:0] LAST_READING = 4'd11;
    localparam logic [3:0] LAST_FIELD   = 4'd13;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_FRAME_ERROR = 2'd1;
    localparam logic [1:0] STATUS_DATA_ERROR  = 2'd2;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_RECV  = 3'd0;
    localparam t_step STEP_RDHI  = 3'd1;
    localparam t_step STEP_RDLO  = 3'd2;
    localparam t_step STEP_EMITP = 3'd3;
    localparam t_step STEP_RDB   = 3'd4;
    localparam t_step STEP_EMITB = 3'd5;
    localparam t_step STEP_DONE  = 3'd6;
    localparam t_step STEP_ERR   = 3'd7;

    typedef enum logic [1:0] {
        ADDR_PAIR_HI = 2'd0,
        ADDR_PAIR_LO = 2'd1,
        ADDR_SINGLE  = 2'd2
    } t_addr_sel;

    typedef enum logic [1:0] {
        EMIT_NONE   = 2'd0,
        EMIT_PAIR   = 2'd1,
        EMIT_SINGLE = 2'd2,
        EMIT_ERROR  = 2'd3
    } t_emit;

    typedef enum logic [1:0] {
        COND_NEXT  = 2'd0,
        COND_FRAME = 2'd1,
        COND_LOOP  = 2'd2,
        COND_JUMP  = 2'd3
    } t_cond;

    typedef struct packed {
        logic      accept;
        logic      rd;
        t_addr_sel addr_sel;
        logic      cap_hi;
        t_emit     emit;
        t_cond     cond;
        t_step     target;
    } t_ctl;

    typedef struct packed {
        logic frame_done;
        logic frame_bad;
        logic slot_free;
        logic group_end;
    } t_dp_status;

    function automatic t_ctl ucode(input t_step step);
        t_ctl w;
        w = '{accept: 1'b0, rd: 1'b0, addr_sel: ADDR_PAIR_HI, cap_hi: 1'b0,
              emit: EMIT_NONE, cond: COND_NEXT, target: STEP_RECV};
        case (step)
            STEP_RECV: begin
                w.accept = 1'b1;
                w.cond   = COND_FRAME;
                w.target = STEP_ERR;
            end
            STEP_RDHI: begin
                w.rd       = 1'b1;
                w.addr_sel = ADDR_PAIR_HI;
            end
            STEP_RDLO: begin
                w.rd       = 1'b1;
                w.addr_sel = ADDR_PAIR_LO;
                w.cap_hi   = 1'b1;
            end
            STEP_EMITP: begin
                w.emit   = EMIT_PAIR;
                w.cond   = COND_LOOP;
                w.target = STEP_RDHI;
            end
            STEP_RDB: begin
                w.rd       = 1'b1;
                w.addr_sel = ADDR_SINGLE;
            end
            STEP_EMITB: begin
                w.emit   = EMIT_SINGLE;
                w.cond   = COND_LOOP;
                w.target = STEP_RDB;
            end
            STEP_DONE: begin
                w.cond   = COND_JUMP;
                w.target = STEP_RECV;
            end
            STEP_ERR: begin
                w.emit   = EMIT_ERROR;
                w.cond   = COND_JUMP;
                w.target = STEP_RECV;
            end
            default: begin
                w.cond   = COND_JUMP;
                w.target = STEP_RECV;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/pfc_sequencer.sv =====
// Step counter and microcode lookup for the particle sensor frame checker.
// Depends on pfc_pkg for the control word, status struct and program table.
`timescale 1ns / 1ps

module pfc_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfc_pkg::t_dp_status i_status,
    output pfc_pkg::t_ctl      o_ctl
);

    pfc_pkg::t_step r_pc;
    pfc_pkg::t_step n_pc;
    pfc_pkg::t_ctl  w_ctl;
    logic           w_go;

    assign w_ctl = pfc_pkg::ucode(r_pc);
    assign o_ctl = w_ctl;
    assign w_go  = (w_ctl.emit == pfc_pkg::EMIT_NONE) || i_status.slot_free;

    always_comb begin
        n_pc = r_pc;
        case (w_ctl.cond)
            pfc_pkg::COND_NEXT: begin
                if (w_go) begin
                    n_pc = r_pc + 3'd1;
                end
            end
            pfc_pkg::COND_FRAME: begin
                if (i_status.frame_done) begin
                    n_pc = i_status.frame_bad ? w_ctl.target : r_pc + 3'd1;
                end
            end
            pfc_pkg::COND_LOOP: begin
                if (w_go) begin
                    n_pc = i_status.group_end ? r_pc + 3'd1 : w_ctl.target;
                end
            end
            pfc_pkg::COND_JUMP: begin
                if (w_go) begin
                    n_pc = w_ctl.target;
                end
            end
            default: begin
                n_pc = pfc_pkg::STEP_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pfc_pkg::STEP_RECV;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== sv/pfc_datapath.sv =====
// Byte intake, frame checks, byte store and result register of the frame checker.
// Depends on pfc_pkg; driven by the control word from pfc_sequencer.
`timescale 1ns / 1ps

module pfc_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfc_pkg::t_ctl       i_ctl,
    input  logic                i_in_valid,
    input  logic [7:0]          i_in_byte,
    input  logic                i_in_start,
    output logic                o_in_ready,
    output pfc_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [3:0]          o_out_index,
    output logic [15:0]         o_out_value,
    output logic [1:0]          o_out_status,
    output logic                o_out_last
);

    logic [7:0]                  r_mem [0:pfc_pkg::STORE_DEPTH-1];
    logic [7:0]                  r_rdata;
    logic [7:0]                  r_hi;
    logic [7:0]                  r_check_hi;
    logic [pfc_pkg::COUNT_W-1:0] r_count;
    logic [pfc_pkg::SUM_W-1:0]   r_sum;
    logic                        r_open;
    logic                        r_hdr_ok;
    logic                        r_err_nz;
    logic [3:0]                  r_fld;
    logic                        r_out_valid;
    logic [3:0]                  r_out_index;
    logic [15:0]                 r_out_value;
    logic [1:0]                  r_out_status;
    logic                        r_out_last;

    logic                        w_take;
    logic                        w_open;
    logic [pfc_pkg::COUNT_W-1:0] w_pos;
    logic [pfc_pkg::SUM_W-1:0]   w_sum_base;
    logic                        w_match;
    logic                        w_done;
    logic                        w_bad;
    logic                        w_slot_free;
    logic                        w_fire;
    logic                        w_group_end;
    logic [pfc_pkg::ADDR_W-1:0]  w_addr;
    logic [1:0]                  w_status;

    assign o_in_ready = i_ctl.accept;
    assign w_take     = i_in_valid && i_ctl.accept;
    assign w_open     = i_in_start || r_open;
    assign w_pos      = i_in_start ? '0 : r_count;
    assign w_sum_base = i_in_start ? '0 : r_sum;
    assign w_done     = w_take && w_open && (w_pos == pfc_pkg::POS_LAST);
    assign w_bad      = ({r_check_hi, i_in_byte} != {3'b000, r_sum}) || !r_hdr_ok;

    always_comb begin
        case (w_pos)
            pfc_pkg::POS_HDR0: w_match = (i_in_byte == pfc_pkg::HDR_FIRST);
            pfc_pkg::POS_HDR1: w_match = (i_in_byte == pfc_pkg::HDR_SECOND);
            pfc_pkg::POS_LEN0: w_match = (i_in_byte == pfc_pkg::LEN_HIGH);
            pfc_pkg::POS_LEN1: w_match = (i_in_byte == pfc_pkg::LEN_LOW);
            default:           w_match = 1'b1;
        endcase
    end

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_fire      = (i_ctl.emit != pfc_pkg::EMIT_NONE) && w_slot_free;
    assign w_group_end = (i_ctl.emit == pfc_pkg::EMIT_PAIR) ? (r_fld == pfc_pkg::LAST_READING)
                                                            : (r_fld == pfc_pkg::LAST_FIELD);
    assign w_status    = r_err_nz ? pfc_pkg::STATUS_DATA_ERROR : pfc_pkg::STATUS_OK;

    assign o_status.frame_done = w_done;
    assign o_status.frame_bad  = w_bad;
    assign o_status.slot_free  = w_slot_free;
    assign o_status.group_end  = w_group_end;

    always_comb begin
        case (i_ctl.addr_sel)
            pfc_pkg::ADDR_PAIR_HI: w_addr = {r_fld, 1'b0} + 5'd4;
            pfc_pkg::ADDR_PAIR_LO: w_addr = {r_fld, 1'b0} + 5'd5;
            pfc_pkg::ADDR_SINGLE:  w_addr = {1'b0, r_fld} + 5'd16;
            default:               w_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_open && (w_pos < pfc_pkg::POS_LAST)) begin
            r_mem[w_pos[pfc_pkg::ADDR_W-1:0]] <= i_in_byte;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[w_addr];
        end
        if (i_ctl.cap_hi) begin
            r_hi <= r_rdata;
        end
        if (w_take && w_open) begin
            if (w_pos == pfc_pkg::POS_CHECK_HI) begin
                r_check_hi <= i_in_byte;
            end
            if (w_pos == pfc_pkg::POS_ERRCODE) begin
                r_err_nz <= (i_in_byte != 8'd0);
            end
            if (w_pos == pfc_pkg::POS_HDR0) begin
                r_hdr_ok <= w_match;
            end else begin
                r_hdr_ok <= r_hdr_ok && w_match;
            end
        end
        if (w_fire) begin
            case (i_ctl.emit)
                pfc_pkg::EMIT_PAIR: begin
                    r_out_index  <= r_fld;
                    r_out_value  <= {r_hi, r_rdata};
                    r_out_status <= w_status;
                    r_out_last   <= 1'b0;
                end
                pfc_pkg::EMIT_SINGLE: begin
                    r_out_index  <= r_fld;
                    r_out_value  <= {8'd0, r_rdata};
                    r_out_status <= w_status;
                    r_out_last   <= (r_fld == pfc_pkg::LAST_FIELD);
                end
                default: begin
                    r_out_index  <= 4'd0;
                    r_out_value  <= 16'd0;
                    r_out_status <= pfc_pkg::STATUS_FRAME_ERROR;
                    r_out_last   <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_open      <= 1'b0;
            r_fld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take && w_open) begin
                r_count <= w_pos + 6'd1;
                r_sum   <= (w_pos < pfc_pkg::POS_CHECK_HI)
                           ? w_sum_base + {5'd0, i_in_byte} : w_sum_base;
                r_open  <= (w_pos != pfc_pkg::POS_LAST);
            end
            if (w_done) begin
                r_fld <= '0;
            end else if (w_fire && (i_ctl.cond == pfc_pkg::COND_LOOP)) begin
                r_fld <= r_fld + 4'd1;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_index  = r_out_index;
    assign o_out_value  = r_out_value;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

// ===== sv/particle_sensor_frame_checker.sv =====
// Top level of the particle sensor frame checker: stream ports around sequencer and datapath.
// Depends on pfc_pkg, pfc_sequencer and pfc_datapath.
//
// Channel   Direction  Item
// s_axis    in         tdata[7:0] rx_byte; tuser frame_start
// m_axis    out        tdata[3:0] field_index, [19:4] field_value, [21:20] frame_status,
//                      [23:22] zero; tlast last_of_frame
//
// Bytes are taken one per cycle while the microprogram sits in its receive step.
// After byte 31 a good frame emits its 14 items in microprogram steps (three steps per
// reading for two reads of the single-port byte store, two per byte field, one to
// return); a bad frame takes one step. Input is not taken during emission.
// Reset is synchronous and active low. A stalled output holds the sequencer in place.
`timescale 1ns / 1ps

module particle_sensor_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // rx_byte
    input  logic        i_s_axis_tuser,   // frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // field_index, field_value, frame_status, zero pad
    output logic        o_m_axis_tlast
);

    pfc_pkg::t_ctl       w_ctl;
    pfc_pkg::t_dp_status w_status;
    logic [3:0]          w_index;
    logic [15:0]         w_value;
    logic [1:0]          w_frame_status;

    pfc_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctl    (w_ctl)
    );

    pfc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_byte    (i_s_axis_tdata),
        .i_in_start   (i_s_axis_tuser),
        .o_in_ready   (o_s_axis_tready),
        .o_status     (w_status),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_index  (w_index),
        .o_out_value  (w_value),
        .o_out_status (w_frame_status),
        .o_out_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, w_frame_status, w_value, w_index};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for particle_sensor_frame_checker: frame table, then random frames.
// Uses pfc_pkg for status codes and frame constants; a local parser predicts items of untyped rows.
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT_NS     = 2_000_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_AT      = 50;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES = 96;
    localparam int FRAME_LEN    = 32;
    localparam int READINGS     = 12;
    localparam int POS_VERSION  = int'(pfc_pkg::POS_ERRCODE) - 1;

    typedef struct packed {
        logic [3:0]  idx;
        logic [15:0] val;
        logic [1:0]  status;
        logic        last;
    } t_field;

    typedef enum logic [1:0] {
        TY_PREDICT = 2'd0,
        TY_NONE    = 2'd1,
        TY_ERROR   = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        PAY_RANDOM = 2'd0,
        PAY_ZERO   = 2'd1,
        PAY_ONES   = 2'd2
    } t_payload;

    typedef enum logic [2:0] {
        CORR_NONE   = 3'd0,
        CORR_SUM    = 3'd1,
        CORR_HDR0   = 3'd2,
        CORR_HDR1   = 3'd3,
        CORR_LEN_HI = 3'd4,
        CORR_LEN_LO = 3'd5
    } t_corrupt;

    typedef struct packed {
        logic [4:0] noise;
        logic [4:0] partial;
        logic       has_frame;
        t_payload   pay;
        logic [7:0] err;
        t_corrupt   corr;
        logic       typed;
    } t_row;

    localparam t_row DIRECTED [13] = '{
        '{5'd4,  5'd0,  1'b0, PAY_RANDOM, 8'h00, CORR_NONE,   1'b1},
        '{5'd0,  5'd0,  1'b1, PAY_ZERO,   8'h00, CORR_NONE,   1'b0},
        '{5'd0,  5'd0,  1'b1, PAY_ONES,   8'hFF, CORR_NONE,   1'b0},
        '{5'd3,  5'd0,  1'b0, PAY_RANDOM, 8'h00, CORR_NONE,   1'b1},
        '{5'd0,  5'd0,  1'b1, PAY_RANDOM, 8'h01, CORR_NONE,   1'b0},
        '{5'd0,  5'd0,  1'b1, PAY_RANDOM, 8'h00, CORR_SUM,    1'b1},
        '{5'd0,  5'd0,  1'b1, PAY_RANDOM, 8'h00, CORR_HDR0,   1'b1},
        '{5'd0,  5'd0,  1'b1, PAY_RANDOM, 8'h00, CORR_HDR1,   1'b1},
        '{5'd0,  5'd0,  1'b1, PAY_RANDOM, 8'h00, CORR_LEN_HI, 1'b1},
        '{5'd0,  5'd0,  1'b1, PAY_ONES,   8'h00, CORR_LEN_LO, 1'b1},
        '{5'd0,  5'd10, 1'b1, PAY_RANDOM, 8'h00, CORR_NONE,   1'b0},
        '{5'd0,  5'd31, 1'b1, PAY_RANDOM, 8'h00, CORR_NONE,   1'b0},
        '{5'd2,  5'd1,  1'b1, PAY_ZERO,   8'hFF, CORR_SUM,    1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    logic [pfc_pkg::COUNT_W-1:0] pr_count;
    logic [pfc_pkg::SUM_W-1:0]   pr_sum;
    logic [7:0]                  pr_store [pfc_pkg::STORE_DEPTH];
    logic                        pr_open;

    t_field     parsed_fields  [$];
    t_field     pending_fields [$];
    logic [7:0] frame_buf [FRAME_LEN];
    logic       src_calm = 1'b0;
    int         n_fail = 0;
    int         frame_byte_count = 0;

    particle_sensor_frame_checker i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL particle_sensor_frame_checker");
        $finish;
    end

    function automatic void note_fail(input string msg);
        n_fail++;
        if (n_fail <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    function automatic int idle_cycles(input logic calm);
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic void parse_frame_byte(input logic [7:0] b, input logic start);
        logic [pfc_pkg::COUNT_W-1:0] pos;
        logic [15:0]                 check;
        logic                        bad;
        logic [1:0]                  st;
        int                          i;
        if (start) begin
            pr_count = '0;
            pr_sum   = '0;
            pr_open  = 1'b1;
        end
        if (!pr_open) begin
            return;
        end
        pos = pr_count;
        if (pos < pfc_pkg::STORE_DEPTH) begin
            pr_store[pos] = b;
        end
        if (pos < pfc_pkg::POS_CHECK_HI) begin
            pr_sum = pr_sum + pfc_pkg::SUM_W'(b);
        end
        pr_count = pos + 1'b1;
        if (pos != pfc_pkg::POS_LAST) begin
            return;
        end
        pr_open = 1'b0;
        check = {pr_store[pfc_pkg::POS_CHECK_HI], b};
        bad = (check != 16'(pr_sum))
            || (pr_store[pfc_pkg::POS_HDR0] != pfc_pkg::HDR_FIRST)
            || (pr_store[pfc_pkg::POS_HDR1] != pfc_pkg::HDR_SECOND)
            || (pr_store[pfc_pkg::POS_LEN0] != pfc_pkg::LEN_HIGH)
            || (pr_store[pfc_pkg::POS_LEN1] != pfc_pkg::LEN_LOW);
        if (bad) begin
            parsed_fields.push_back(t_field'{4'd0, 16'd0, pfc_pkg::STATUS_FRAME_ERROR, 1'b1});
            return;
        end
        st = (pr_store[pfc_pkg::POS_ERRCODE] != 8'd0) ? pfc_pkg::STATUS_DATA_ERROR
                                                      : pfc_pkg::STATUS_OK;
        for (i = 0; i < READINGS; i++) begin
            parsed_fields.push_back(t_field'{4'(i),
                                             {pr_store[4 + 2 * i], pr_store[5 + 2 * i]},
                                             st, 1'b0});
        end
        parsed_fields.push_back(t_field'{4'd12, {8'd0, pr_store[POS_VERSION]}, st, 1'b0});
        parsed_fields.push_back(t_field'{pfc_pkg::LAST_FIELD,
                                         {8'd0, pr_store[pfc_pkg::POS_ERRCODE]}, st, 1'b1});
    endfunction

    function automatic void build_frame(input t_payload pay, input logic [7:0] err,
                                        input t_corrupt corr);
        logic [15:0] sum;
        int          k;
        frame_buf[pfc_pkg::POS_HDR0] = pfc_pkg::HDR_FIRST;
        frame_buf[pfc_pkg::POS_HDR1] = pfc_pkg::HDR_SECOND;
        frame_buf[pfc_pkg::POS_LEN0] = pfc_pkg::LEN_HIGH;
        frame_buf[pfc_pkg::POS_LEN1] = pfc_pkg::LEN_LOW;
        for (k = 4; k < pfc_pkg::POS_ERRCODE; k++) begin
            case (pay)
                PAY_ZERO: frame_buf[k] = 8'h00;
                PAY_ONES: frame_buf[k] = 8'hFF;
                default:  frame_buf[k] = 8'($urandom);
            endcase
        end
        frame_buf[pfc_pkg::POS_ERRCODE] = err;
        case (corr)
            CORR_HDR0:   frame_buf[pfc_pkg::POS_HDR0] ^= 8'(1 << $urandom_range(0, 7));
            CORR_HDR1:   frame_buf[pfc_pkg::POS_HDR1] ^= 8'(1 << $urandom_range(0, 7));
            CORR_LEN_HI: frame_buf[pfc_pkg::POS_LEN0] ^= 8'(1 << $urandom_range(0, 7));
            CORR_LEN_LO: frame_buf[pfc_pkg::POS_LEN1] ^= 8'(1 << $urandom_range(0, 7));
            default: ;
        endcase
        sum = 16'd0;
        for (k = 0; k < pfc_pkg::POS_CHECK_HI; k++) begin
            sum = sum + 16'(frame_buf[k]);
        end
        if (corr == CORR_SUM) begin
            sum ^= 16'(1 << $urandom_range(0, 15));
        end
        frame_buf[pfc_pkg::POS_CHECK_HI] = sum[15:8];
        frame_buf[pfc_pkg::POS_LAST]     = sum[7:0];
    endfunction

    function automatic t_row random_row();
        t_row r;
        int   pick;
        r = '{5'd0, 5'd0, 1'b1, PAY_RANDOM, 8'h00, CORR_NONE, 1'b0};
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) begin
            r.pay = ($urandom_range(0, 1) == 0) ? PAY_ZERO : PAY_ONES;
        end
        if ($urandom_range(0, 9) < 3) begin
            r.err = 8'($urandom_range(1, 255));
        end
        if (pick >= 55 && pick < 80) begin
            r.corr = t_corrupt'($urandom_range(1, 5));
        end else if (pick >= 80 && pick < 90) begin
            r.partial = 5'($urandom_range(1, 31));
        end else if (pick >= 90) begin
            r.noise = 5'($urandom_range(1, 6));
        end
        return r;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic start, input t_outcome ty);
        int gap;
        gap = idle_cycles(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        parsed_fields.delete();
        parse_frame_byte(b, start);
        case (ty)
            TY_PREDICT: begin
                while (parsed_fields.size() != 0) begin
                    pending_fields.push_back(parsed_fields.pop_front());
                end
            end
            TY_ERROR: pending_fields.push_back(
                t_field'{4'd0, 16'd0, pfc_pkg::STATUS_FRAME_ERROR, 1'b1});
            default: ;
        endcase
    endtask

    task automatic send_row(input t_row r);
        t_outcome quiet;
        t_outcome ty;
        int       k;
        quiet = r.typed ? TY_NONE : TY_PREDICT;
        src_calm = ($urandom_range(0, 3) == 0);
        for (k = 0; k < r.noise; k++) begin
            push_byte(8'($urandom), 1'b0, quiet);
        end
        if (r.partial != 0) begin
            build_frame(PAY_RANDOM, 8'($urandom), CORR_NONE);
            for (k = 0; k < r.partial; k++) begin
                push_byte(frame_buf[k], k == 0, quiet);
            end
            frame_byte_count += r.partial;
        end
        if (r.has_frame) begin
            build_frame(r.pay, r.err, r.corr);
            for (k = 0; k < FRAME_LEN; k++) begin
                ty = (k == FRAME_LEN - 1 && r.typed && r.corr != CORR_NONE) ? TY_ERROR : quiet;
                push_byte(frame_buf[k], k == 0, ty);
            end
            frame_byte_count += FRAME_LEN;
        end
    endtask

    // The receiver stalls for a long stretch once, so the sender backs up against a full block.
    initial begin
        int   gap;
        int   n_taken;
        logic rcv_calm;
        n_taken  = 0;
        rcv_calm = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                rcv_calm = ~rcv_calm;
            end
            gap = (n_taken == HOLD_AT) ? HOLD_CYCLES : idle_cycles(rcv_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            n_taken++;
        end
    end

    always @(posedge clk) begin : check_output
        t_field want;
        t_field got;
        if (rst_n && m_tvalid && m_tready) begin
            got = '{m_tdata[3:0], m_tdata[19:4], m_tdata[21:20], m_tlast};
            if (pending_fields.size() == 0) begin
                note_fail($sformatf("unexpected item idx %0d val %h st %0d last %b",
                                    got.idx, got.val, got.status, got.last));
            end else begin
                want = pending_fields.pop_front();
                if (got.idx != want.idx || got.val != want.val || got.status != want.status
                    || got.last != want.last || m_tdata[23:22] != 2'b00) begin
                    note_fail($sformatf(
                        {"want idx %0d val %h st %0d last %b, ",
                         "got idx %0d val %h st %0d last %b pad %b"},
                        want.idx, want.val, want.status, want.last,
                        got.idx, got.val, got.status, got.last, m_tdata[23:22]));
                end
            end
        end
    end

    initial begin
        int i;
        pr_count = '0;
        pr_sum   = '0;
        pr_open  = 1'b0;
        for (i = 0; i < pfc_pkg::STORE_DEPTH; i++) begin
            pr_store[i] = 8'd0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < $size(DIRECTED); i++) begin
            send_row(DIRECTED[i]);
        end
        frame_byte_count = 0;
        while (frame_byte_count < RANDOM_BYTES) begin
            send_row(random_row());
        end
        s_tvalid <= 1'b0;
        while (pending_fields.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0) begin
            $display("PASS particle_sensor_frame_checker");
        end else begin
            $display("FAIL particle_sensor_frame_checker");
        end
        $finish;
    end

endmodule
